// ----- src/nms_pkg.sv -----
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants of the neuron MAC with softsign
// Defaults for the widths, the fixed output format and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 40;

  // Integer bits of the input format; the rest of a data word is fraction.
  localparam int IN_INT_BITS = 4;

  // The activation is signed Q1.15.
  localparam int OUT_WIDTH = 16;
  localparam int OUT_FRAC  = 15;
  localparam int Q_BITS    = OUT_FRAC + 1;
  localparam logic [OUT_FRAC-1:0] OUT_MAX = {OUT_FRAC{1'b1}};

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic acc_add;
    logic load_div;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

// ----- src/nms_term_if.sv -----
// ----------------------------------------------------------------------------
// nms_term_if: connection term channel
// Carries one weight, one source value and the last-term flag per item.
// ----------------------------------------------------------------------------
interface nms_term_if #(
  parameter int DATA_WIDTH = nms_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] term_weight;
  logic signed [DATA_WIDTH-1:0] term_value;
  logic                         term_last;

  modport source(output valid, output term_weight, output term_value,
                 output term_last, input ready);
  modport sink(input valid, input term_weight, input term_value,
               input term_last, output ready);
endinterface

// ----- src/nms_act_if.sv -----
// ----------------------------------------------------------------------------
// nms_act_if: activation result channel
// Carries one signed Q1.15 activation per item.
// ----------------------------------------------------------------------------
interface nms_act_if;
  logic                               valid;
  logic                               ready;
  logic signed [nms_pkg::OUT_WIDTH-1:0] activation;

  modport source(output valid, output activation, input ready);
  modport sink(input valid, input activation, output ready);
endinterface

// ----- src/nms_datapath.sv -----
// ----------------------------------------------------------------------------
// nms_datapath: multiplier, saturating accumulator and softsign divider
// Registers the product of each term, adds it into the saturating sum and
// divides |sum| by (1 + |sum|) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nms_datapath #(
  parameter int DATA_WIDTH = nms_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = nms_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nms_pkg::cmd_t                       cmd,
  output nms_pkg::stat_t                      stat,
  input  logic                                in_valid,
  input  logic signed [DATA_WIDTH-1:0]        term_weight,
  input  logic signed [DATA_WIDTH-1:0]        term_value,
  input  logic                                term_last,
  output logic                                act_valid,
  input  logic                                act_ready,
  output logic signed [nms_pkg::OUT_WIDTH-1:0] activation
);

  localparam int PW    = 2 * DATA_WIDTH;
  localparam int SF    = 2 * (DATA_WIDTH - nms_pkg::IN_INT_BITS);
  localparam int SW    = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int DEN_W = ((ACC_WIDTH > SF + 1) ? ACC_WIDTH : SF + 1) + 1;
  localparam int QB    = nms_pkg::Q_BITS;
  localparam int OF    = nms_pkg::OUT_FRAC;

  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_c;
  logic                        last;
  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [SW-1:0]        sum;
  logic                        sum_fits;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic                        acc_neg;
  logic [ACC_WIDTH-1:0]        mag;
  logic [DEN_W-1:0]            den_c;
  logic [DEN_W-1:0]            rem;
  logic [DEN_W-1:0]            den;
  logic [DEN_W:0]              rem2;
  logic                        q_bit;
  logic [QB-1:0]               q;
  logic                        neg;
  logic [QB:0]                 q_inc;
  logic [QB-1:0]               q_rnd;
  logic [OF-1:0]               q_mag;
  logic [nms_pkg::OUT_WIDTH-1:0] res;

  assign prod_c = term_weight * term_value;

  // The sum fits when all bits from the accumulator's sign bit upward agree.
  assign sum      = SW'(acc) + SW'(prod);
  assign sum_fits = (&sum[SW-1:ACC_WIDTH-1]) || !(|sum[SW-1:ACC_WIDTH-1]);
  always_comb begin
    if (sum_fits) begin
      sum_sat = sum[ACC_WIDTH-1:0];
    end else if (sum[SW-1]) begin
      sum_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  end

  assign acc_neg = acc[ACC_WIDTH-1];
  assign mag     = acc_neg ? (~acc + 1'b1) : acc;
  assign den_c   = DEN_W'(mag) + (DEN_W'(1) << SF);

  assign rem2  = {rem, 1'b0};
  assign q_bit = (rem2 >= {1'b0, den});

  // Round half up on the extra quotient bit, then hold below one.
  assign q_inc = {1'b0, q} + (QB + 1)'(1);
  assign q_rnd = q_inc[QB:1];
  assign q_mag = q_rnd[QB-1] ? nms_pkg::OUT_MAX : q_rnd[OF-1:0];
  assign res   = neg ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod <= prod_c;
      last <= term_last;
    end
    if (cmd.load_div) begin
      rem <= DEN_W'(mag);
      den <= den_c;
      q   <= '0;
      neg <= acc_neg;
    end else if (cmd.div_step) begin
      rem <= q_bit ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
      q   <= {q[QB-2:0], q_bit};
    end
    if (cmd.emit) begin
      activation <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      act_valid <= 1'b0;
    end else begin
      if (cmd.acc_add) begin
        acc <= sum_sat;
      end else if (cmd.load_div) begin
        acc <= '0;
      end
      if (cmd.emit) begin
        act_valid <= 1'b1;
      end else if (act_ready) begin
        act_valid <= 1'b0;
      end
    end
  end

  assign stat.in_valid = in_valid;
  assign stat.last     = last;
  assign stat.out_busy = act_valid && !act_ready;

endmodule

// ----- src/nms_ctrl.sv -----
// ----------------------------------------------------------------------------
// nms_ctrl: sequencer of the neuron MAC with softsign
// Steps each term through capture and accumulate, and on the last term
// through the magnitude load, the quotient bits and the result write.
// ----------------------------------------------------------------------------
module nms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  nms_pkg::stat_t stat,
  output nms_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int CW = $clog2(nms_pkg::Q_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(nms_pkg::Q_BITS - 1);

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = stat.last ? S_ABS : S_IDLE;
      end
      S_ABS: begin
        cmd.load_div = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- src/neuron_mac_softsign.sv -----
// ----------------------------------------------------------------------------
// neuron_mac_softsign: weighted sum of one neuron with softsign activation
// Accumulates weight * value per term and emits sum / (1 + |sum|) as Q1.15
// on the term marked last.
// ----------------------------------------------------------------------------
// For each term item, the product is registered when the item is accepted
// and added into the saturating accumulator in the next cycle. After a term
// marked last, the magnitude and divisor are loaded, the restoring divider
// produces one quotient bit per cycle, and the quotient is rounded into the
// result register before the next term is accepted. The result waits in that
// register while the next neuron's terms are taken; a new result is written
// only once the previous one is taken.
module neuron_mac_softsign #(
  parameter int DATA_WIDTH = nms_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = nms_pkg::ACC_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  nms_term_if.sink  term,
  nms_act_if.source act
);

  nms_pkg::cmd_t  cmd;
  nms_pkg::stat_t stat;

  logic signed [DATA_WIDTH-1:0] w_in;
  logic signed [DATA_WIDTH-1:0] v_in;

  assign w_in       = term.term_weight[DATA_WIDTH-1:0];
  assign v_in       = term.term_value[DATA_WIDTH-1:0];
  assign term.ready = cmd.in_ready;

  nms_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  nms_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_valid    (term.valid),
    .term_weight (w_in),
    .term_value  (v_in),
    .term_last   (term.term_last),
    .act_valid   (act.valid),
    .act_ready   (act.ready),
    .activation  (act.activation)
  );

`ifndef SYNTH
  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    term.valid && term.ready |=> !term.ready)
    else $error("term item accepted while the previous one is in work");

  // A result appears only from the write step after the divider.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(act.valid) |-> $past(cmd.emit))
    else $error("activation became valid without a result write");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result written while the previous one waits");

  // The divider is never loaded or stepped, nor the sum updated, while a term is taken.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && (cmd.load_div || cmd.div_step || cmd.acc_add)))
    else $error("conflicting datapath commands");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the neuron MAC with softsign activation
// Streams connection terms into the block, predicts each neuron's Q1.15
// activation with a saturating 40-bit accumulator and a bit-serial divider,
// and compares every activation taken from the block in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int DW       = nms_pkg::DATA_WIDTH_DEF;
  localparam int AW       = nms_pkg::ACC_WIDTH_DEF;
  localparam int SUM_FRAC = 2 * (DW - nms_pkg::IN_INT_BITS);
  localparam longint ACC_HI = (64'sd1 <<< (AW - 1)) - 64'sd1;
  localparam longint ACC_LO = -ACC_HI - 64'sd1;

  // Ways of drawing a data word for a term.
  localparam int PICK_FULL    = 0;
  localparam int PICK_NEAR    = 1;
  localparam int PICK_EXTREME = 2;
  localparam int PICK_MIXED   = 3;

  class neuron_scoreboard;
    longint                               neuron_sum;
    logic signed [nms_pkg::OUT_WIDTH-1:0] expected_acts[$];
    int                                   errors;

    function new();
      neuron_sum = 0;
      errors     = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Restoring division of |s| by |s| + 1.0, rounded half away from zero.
    function logic signed [nms_pkg::OUT_WIDTH-1:0] softsign_q15(longint s);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned rem;
      longint unsigned quo;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      den = mag + (64'd1 << SUM_FRAC);
      rem = mag;
      quo = 0;
      for (int i = 0; i < nms_pkg::Q_BITS; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo = quo | 64'd1;
        end
      end
      quo = (quo + 64'd1) >> 1;
      if (quo > nms_pkg::OUT_MAX)
        quo = nms_pkg::OUT_MAX;
      return (s < 0) ? 16'(-quo) : 16'(quo);
    endfunction

    function void add_term(logic signed [DW-1:0] w, logic signed [DW-1:0] v, logic last);
      longint next_sum;
      next_sum = neuron_sum + longint'(w) * longint'(v);
      if (next_sum > ACC_HI)
        next_sum = ACC_HI;
      else if (next_sum < ACC_LO)
        next_sum = ACC_LO;
      neuron_sum = next_sum;
      if (last) begin
        expected_acts.push_back(softsign_q15(neuron_sum));
        neuron_sum = 0;
      end
    endfunction

    task check_activation(logic signed [nms_pkg::OUT_WIDTH-1:0] got);
      logic signed [nms_pkg::OUT_WIDTH-1:0] want;
      if (expected_acts.size() == 0) begin
        report_mismatch($sformatf("activation %0d arrived with none pending", got));
      end else begin
        want = expected_acts.pop_front();
        if (got !== want)
          report_mismatch($sformatf("activation %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   src_burst;
  bit   snk_burst;

  nms_term_if #(.DATA_WIDTH(DW)) term_ch ();
  nms_act_if                     act_ch ();

  neuron_scoreboard score = new();

  neuron_mac_softsign #(
    .DATA_WIDTH(DW),
    .ACC_WIDTH (AW)
  ) dut (
    .clk (clk),
    .rst (rst),
    .term(term_ch),
    .act (act_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_data(int mode);
    int m;
    m = (mode == PICK_MIXED) ? $urandom_range(PICK_FULL, PICK_EXTREME) : mode;
    case (m)
      PICK_NEAR: begin
        return int'($urandom_range(0, 16383)) - 8192;
      end
      PICK_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      default: begin
        return int'($signed(DW'($urandom())));
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the term is taken.
  task automatic send_term(input int w, input int v, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0)
      src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      term_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    term_ch.valid       <= 1'b1;
    term_ch.term_weight <= DW'(w);
    term_ch.term_value  <= DW'(v);
    term_ch.term_last   <= last;
    do @(posedge clk); while (!term_ch.ready);
    score.add_term(DW'(w), DW'(v), last);
  endtask

  // Long run of extreme products that drives the sum into its limit, then a term
  // of 1.0 against it that must start from the held limit, and two random terms.
  task automatic saturate_neuron(input bit positive);
    for (int i = 0; i < 514; i++) begin
      if (positive && $urandom_range(0, 1))
        send_term(-32768, -32768, 1'b0);
      else if (positive)
        send_term(32767, 32767, 1'b0);
      else if ($urandom_range(0, 1))
        send_term(-32768, 32767, 1'b0);
      else
        send_term(32767, -32768, 1'b0);
    end
    send_term(4096, positive ? -4096 : 4096, 1'b0);
    send_term(pick_data(PICK_FULL), pick_data(PICK_FULL), 1'b0);
    send_term(pick_data(PICK_FULL), pick_data(PICK_FULL), 1'b1);
  endtask

  initial begin
    int stall;
    act_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0)
        snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        act_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      act_ch.ready <= 1'b1;
      do @(posedge clk); while (!act_ch.valid);
      score.check_activation(act_ch.activation);
    end
  end

  initial begin
    int sent;
    int len;
    int mode;
    rst                 = 1'b1;
    term_ch.valid       = 1'b0;
    term_ch.term_weight = '0;
    term_ch.term_value  = '0;
    term_ch.term_last   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A node without connections arrives as one zero-weight term.
    send_term(0, 12345, 1'b1);
    send_term(32767, 32767, 1'b1);
    send_term(-32768, 32767, 1'b1);
    send_term(-32768, -32768, 1'b1);
    send_term(1, 1, 1'b1);
    send_term(-1, 1, 1'b1);
    // Sums of exactly +1.0 and -1.0 give one half.
    send_term(4096, 4096, 1'b1);
    send_term(-4096, 4096, 1'b1);
    send_term(100, 200, 1'b0);
    send_term(-100, 200, 1'b1);
    send_term(32767, -32768, 1'b0);
    send_term(0, 0, 1'b0);
    send_term(12345, -6789, 1'b1);
    send_term(-32768, 0, 1'b1);
    send_term(-21846, 21845, 1'b0);
    send_term(-1, -1, 1'b1);

    saturate_neuron($urandom_range(0, 1) == 1);

    sent = 0;
    while (sent < 150) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      mode = $urandom_range(PICK_FULL, PICK_MIXED);
      for (int i = 0; i < len; i++) begin
        send_term(pick_data(mode), pick_data(mode), i == len - 1);
        sent++;
      end
    end
    term_ch.valid <= 1'b0;

    while (score.expected_acts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (score.errors == 0 && score.expected_acts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nms_pkg.sv
src/nms_term_if.sv
src/nms_act_if.sv
src/nms_datapath.sv
src/nms_ctrl.sv
src/neuron_mac_softsign.sv
tb/tb_top.sv
